// ===== rtl/core/vertex_matrix_transform_defines.svh =====
// assertion macros for the vertex matrix transform
// no dependencies; taken in by the files that assert
`ifndef VERTEX_MATRIX_TRANSFORM_DEFINES_SVH
`define VERTEX_MATRIX_TRANSFORM_DEFINES_SVH

// same-cycle implication, off while reset is high
`define VMT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vmt assertion failed");

// next-cycle implication, also checked across reset
`define VMT_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("vmt assertion failed");

`endif

// ===== rtl/core/vmt_pkg.sv =====
// shared widths, types and reset constants for the vertex matrix transform
// no dependencies
`default_nettype none

package vmt_pkg;

   localparam int COORD_W   = 32;
   localparam int FRAC_W    = 16;
   localparam int NUM_DIM   = 4;
   localparam int NUM_CSR   = 8;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = $clog2(NUM_CSR);
   localparam int PROD_W    = 2 * COORD_W;
   localparam int SUM_W     = PROD_W + $clog2(NUM_DIM);
   localparam int SHIFT_W   = SUM_W - FRAC_W;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [NUM_DIM-1:0]   vec_type;

   typedef struct packed {
      coord_type value;
      logic      sat;
   } col_result_type;

   // identity matrix, register 7 first
   localparam logic [NUM_CSR-1:0][CSR_W-1:0] MAT_RESET = {
      64'h0001_0000_0000_0000, 64'h0,
      64'h0000_0000_0001_0000, 64'h0,
      64'h0,                   64'h0001_0000_0000_0000,
      64'h0,                   64'h0000_0000_0001_0000
   };

endpackage

`default_nettype wire

// ===== rtl/core/vmt_req_if.sv =====
// vertex input channel: valid/ready handshake with the four coordinates
// depends on vmt_pkg
`default_nettype none

interface vmt_req_if;
   import vmt_pkg::*;

   logic      valid;
   logic      ready;
   coord_type in_x;
   coord_type in_y;
   coord_type in_z;
   coord_type in_w;

   modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                   input ready);
   modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vmt_rsp_if.sv =====
// transformed vertex channel: valid/ready handshake with result and flag
// depends on vmt_pkg
`default_nettype none

interface vmt_rsp_if;
   import vmt_pkg::*;

   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   coord_type out_w;
   logic      saturated;

   modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                   output saturated, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                   input saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vertex_matrix_transform.sv =====
// top level: 4x4 Q16.16 matrix times homogeneous vertex, three-stage pipeline
// depends on vmt_pkg, vmt_req_if, vmt_rsp_if, vmt_column and the defines header
//
// usage:
//   req_chan carries one vertex (in_x, in_y, in_z, in_w) per transfer, rsp_chan
//   one transformed vertex (out_x .. out_w) plus the saturated flag per transfer.
//   the vertex is taken as a row vector: out_j = sum of in_i * m[i][j].
//   the matrix sits in eight 64-bit registers written through csr_wr_en,
//   csr_index and csr_wr_data (even column in the low half, odd column high).
//   write them only while no vertex is in flight.
//   a vertex is registered in the input register, then the product register,
//   and its result is offered from the result register.
//   throughput: one vertex per cycle while rsp_chan takes results, set by the
//   sixteen parallel 32x32 multipliers between the input and product registers.
//   a stalled rsp_chan holds its result; stages behind it keep filling, and
//   req_chan.ready drops only when all three stages hold a vertex.
//   reset (synchronous) empties the pipeline and loads the identity matrix.
`default_nettype none

`include "vertex_matrix_transform_defines.svh"

module vertex_matrix_transform (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [vmt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vmt_pkg::CSR_W-1:0]      csr_wr_data,
   vmt_req_if.sink                        req_chan,
   vmt_rsp_if.source                      rsp_chan
);
   import vmt_pkg::*;

   logic [NUM_CSR-1:0][CSR_W-1:0] mat_ff;

   vec_type        in_vec_ff;
   logic           in_valid_ff;
   logic           in_valid_in;
   logic           prod_valid_ff;
   logic           prod_valid_in;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic           in_en;
   logic           prod_en;
   logic           out_en;
   vec_type        coef   [NUM_DIM];
   col_result_type col_res[NUM_DIM];
   vec_type        out_vec_ff;
   logic           out_sat_ff;

   // a stage advances when the one after it is empty or moving
   assign out_en  = !out_valid_ff || rsp_chan.ready;
   assign prod_en = !prod_valid_ff || out_en;
   assign in_en   = !in_valid_ff || prod_en;

   assign req_chan.ready = in_en;

   assign in_valid_in   = in_en   ? req_chan.valid : in_valid_ff;
   assign prod_valid_in = prod_en ? in_valid_ff    : prod_valid_ff;
   assign out_valid_in  = out_en  ? prod_valid_ff  : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff        <= MAT_RESET;
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mat_ff[csr_index] <= csr_wr_data;
         end
         in_valid_ff   <= in_valid_in;
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_en) begin
         in_vec_ff <= {req_chan.in_w, req_chan.in_z, req_chan.in_y, req_chan.in_x};
      end
      if (out_en) begin
         for (int j = 0; j < NUM_DIM; j++) begin
            out_vec_ff[j] <= col_res[j].value;
         end
         out_sat_ff <= col_res[0].sat | col_res[1].sat | col_res[2].sat | col_res[3].sat;
      end
   end

   // m[i][j] lives in register 2i + j/2, half j%2
   always_comb begin
      for (int j = 0; j < NUM_DIM; j++) begin
         for (int i = 0; i < NUM_DIM; i++) begin
            coef[j][i] = mat_ff[CSR_IDX_W'(2 * i + j / 2)][(j % 2) * COORD_W +: COORD_W];
         end
      end
   end

   for (genvar j = 0; j < NUM_DIM; j++) begin : g_col
      vmt_column u_col (
         .clock   (clock),
         .prod_en (prod_en),
         .vec     (in_vec_ff),
         .coef    (coef[j]),
         .result  (col_res[j])
      );
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_x     = out_vec_ff[0];
   assign rsp_chan.out_y     = out_vec_ff[1];
   assign rsp_chan.out_z     = out_vec_ff[2];
   assign rsp_chan.out_w     = out_vec_ff[3];
   assign rsp_chan.saturated = out_sat_ff;

   // a full pipeline behind a stalled output must refuse new vertices
   `VMT_ASSERT_IMPLY(a_full_stall, clock, reset,
      in_valid_ff && prod_valid_ff && out_valid_ff && !rsp_chan.ready, !req_chan.ready)
   // a product stage moving forward lands in the result register
   `VMT_ASSERT_NEXT(a_prod_advance, clock,
      !reset && prod_valid_ff && out_en, out_valid_ff)
   // the flag only appears with at least one component pinned to a limit
   `VMT_ASSERT_IMPLY(a_sat_limit, clock, reset, rsp_chan.valid && rsp_chan.saturated,
      rsp_chan.out_x == 32'h7fffffff || rsp_chan.out_x == 32'h80000000 ||
      rsp_chan.out_y == 32'h7fffffff || rsp_chan.out_y == 32'h80000000 ||
      rsp_chan.out_z == 32'h7fffffff || rsp_chan.out_z == 32'h80000000 ||
      rsp_chan.out_w == 32'h7fffffff || rsp_chan.out_w == 32'h80000000)
   // reset leaves nothing to deliver
   `VMT_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_chan.valid && req_chan.ready)

endmodule

`default_nettype wire

// ===== rtl/core/vmt_column.sv =====
// one output column: four registered 32x32 products, then sum, shift, saturate
// depends on vmt_pkg
`default_nettype none

module vmt_column (
   input  logic                    clock,
   input  logic                    prod_en,
   input  vmt_pkg::vec_type        vec,
   input  vmt_pkg::vec_type        coef,
   output vmt_pkg::col_result_type result
);
   import vmt_pkg::*;

   logic signed [PROD_W-1:0]  prod_in [NUM_DIM];
   logic signed [PROD_W-1:0]  prod_ff [NUM_DIM];
   logic signed [SUM_W-1:0]   sum;
   logic signed [SHIFT_W-1:0] shifted;
   logic [SHIFT_W-COORD_W:0]  upper;

   always_comb begin
      for (int i = 0; i < NUM_DIM; i++) begin
         // operands sign-extend to the product width, so the product is exact
         prod_in[i] = $signed(vec[i]) * $signed(coef[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (prod_en) begin
         for (int i = 0; i < NUM_DIM; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

   always_comb begin
      sum = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2])
          + SUM_W'(prod_ff[3]);
      // arithmetic shift floors toward minus infinity
      shifted = SHIFT_W'(sum >>> FRAC_W);
      upper   = shifted[SHIFT_W-1:COORD_W-1];
      if (upper == '0 || upper == '1) begin
         result.value = shifted[COORD_W-1:0];
         result.sat   = 1'b0;
      end else if (shifted[SHIFT_W-1]) begin
         result.value = {1'b1, {(COORD_W-1){1'b0}}};
         result.sat   = 1'b1;
      end else begin
         result.value = {1'b0, {(COORD_W-1){1'b1}}};
         result.sat   = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== sim/vmt_tb_pkg.sv =====
// register names and the result scoreboard for the vertex matrix transform bench
// depends on vmt_pkg
package vmt_tb_pkg;
   import vmt_pkg::*;

   typedef enum logic [CSR_IDX_W-1:0] {
      ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23,
      ROW2_COLS01, ROW2_COLS23, ROW3_COLS01, ROW3_COLS23
   } mat_reg_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      coord_type w;
      logic      sat;
   } vertex_result_type;

   localparam longint COORD_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam longint COORD_LO = -64'sh0000_0000_8000_0000;

   class vertex_xform_scoreboard;
      logic [CSR_W-1:0]  mat_reg [NUM_CSR];
      vertex_result_type expected_vertices [$];
      int unsigned       errors;

      function new();
         errors = 0;
         for (int k = 0; k < NUM_CSR; k++) mat_reg[k] = MAT_RESET[k];
      endfunction

      function void write_reg(mat_reg_type idx, logic [CSR_W-1:0] val);
         mat_reg[idx] = val;
      endfunction

      // even column in the low half, odd column in the high half
      function coord_type element(int row, int col);
         logic [CSR_W-1:0] r;
         r = mat_reg[row * 2 + col / 2];
         return (col % 2 == 1) ? r[CSR_W-1 -: COORD_W] : r[COORD_W-1:0];
      endfunction

      function vertex_result_type transform_vertex(vec_type v);
         logic signed [SUM_W-1:0] acc;
         longint                  prod;
         longint                  q;
         coord_type               res [NUM_DIM];
         logic                    sat;
         vertex_result_type       r;
         sat = 1'b0;
         for (int j = 0; j < NUM_DIM; j++) begin
            acc = '0;
            for (int i = 0; i < NUM_DIM; i++) begin
               prod = longint'(signed'(v[i])) * longint'(signed'(element(i, j)));
               acc += prod;
            end
            // arithmetic shift floors, so negative sums round down
            q = longint'(acc >>> FRAC_W);
            if (q > COORD_HI) begin
               res[j] = 32'sh7FFF_FFFF;
               sat = 1'b1;
            end else if (q < COORD_LO) begin
               res[j] = 32'sh8000_0000;
               sat = 1'b1;
            end else begin
               res[j] = q[COORD_W-1:0];
            end
         end
         r.x = res[0];
         r.y = res[1];
         r.z = res[2];
         r.w = res[3];
         r.sat = sat;
         return r;
      endfunction

      function void note_vertex(vec_type v);
         expected_vertices.push_back(transform_vertex(v));
      endfunction

      function void compare_field(string name, longint exp_val, longint act_val);
         if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_result(vertex_result_type got);
         vertex_result_type exp_res;
         if (expected_vertices.size() == 0) begin
            $error("result transfer with no vertex outstanding");
            errors++;
            return;
         end
         exp_res = expected_vertices.pop_front();
         compare_field("out_x", longint'(exp_res.x), longint'(got.x));
         compare_field("out_y", longint'(exp_res.y), longint'(got.y));
         compare_field("out_z", longint'(exp_res.z), longint'(got.z));
         compare_field("out_w", longint'(exp_res.w), longint'(got.w));
         compare_field("saturated", longint'(exp_res.sat), longint'(got.sat));
      endfunction

      function int pending();
         return expected_vertices.size();
      endfunction
   endclass

endpackage

// ===== sim/tb_vertex_matrix_transform.sv =====
// self-checking bench: directed and random vertices through several matrix settings
// depends on vmt_pkg, vmt_req_if, vmt_rsp_if, vmt_tb_pkg and the vertex_matrix_transform rtl
module tb_vertex_matrix_transform;
   timeunit 1ns;
   timeprecision 1ps;

   import vmt_pkg::*;
   import vmt_tb_pkg::*;

   localparam coord_type Q_ONE  = 32'sh0001_0000;
   localparam coord_type Q_HALF = 32'sh0000_8000;
   localparam coord_type Q_MAX  = 32'sh7FFF_FFFF;
   localparam coord_type Q_MIN  = 32'sh8000_0000;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wr_data;

   vmt_req_if req_chan ();
   vmt_rsp_if rsp_chan ();

   vertex_xform_scoreboard xform_sb = new();

   logic [CSR_W-1:0] next_matrix [NUM_CSR];
   int               burst_left;

   vertex_matrix_transform dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // receiver: a 16-bit ready mask, played one to four times, then a new one
   initial begin : rsp_stall_pattern
      logic [15:0] mask;
      rsp_chan.ready = 1'b0;
      forever begin
         case ($urandom_range(0, 3))
            0: mask = 16'hFFFF;
            1: mask = 16'($urandom());
            2: mask = 16'($urandom()) & 16'($urandom());
            default: mask = 16'($urandom()) | 16'($urandom());
         endcase
         repeat ($urandom_range(1, 4)) begin
            for (int k = 0; k < 16; k++) begin
               @(negedge clock);
               rsp_chan.ready <= mask[k];
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         xform_sb.note_vertex({req_chan.in_w, req_chan.in_z, req_chan.in_y, req_chan.in_x});
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         xform_sb.check_result({rsp_chan.out_x, rsp_chan.out_y, rsp_chan.out_z,
                                rsp_chan.out_w, rsp_chan.saturated});
   end

   function automatic vec_type make_vertex(coord_type x, coord_type y, coord_type z,
                                           coord_type w);
      return {w, z, y, x};
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(0, 9))
         0, 1, 2: return coord_type'($urandom());
         3, 4, 5: return coord_type'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
         6: begin
            case ($urandom_range(0, 5))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return '0;
               3: return -32'sd1;
               4: return 32'sd1;
               default: return Q_ONE;
            endcase
         end
         default: return (coord_type'($urandom_range(0, 8)) - 32'sd4) <<< FRAC_W;
      endcase
   endfunction

   function automatic vec_type random_vertex();
      coord_type w;
      w = ($urandom_range(0, 9) < 6) ? Q_ONE : random_coord();
      return make_vertex(random_coord(), random_coord(), random_coord(), w);
   endfunction

   // matrix entries: kind 0 small (within +-4.0), 1 any value, 2 sparse
   function automatic coord_type random_element(int kind);
      case (kind)
         0: return coord_type'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         1: return coord_type'($urandom());
         default: return ($urandom_range(0, 2) == 0) ? coord_type'($urandom()) : '0;
      endcase
   endfunction

   task automatic write_matrix_reg(mat_reg_type idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      xform_sb.write_reg(idx, val);
   endtask

   task automatic load_matrix();
      for (int k = 0; k < NUM_CSR; k++) write_matrix_reg(mat_reg_type'(k), next_matrix[k]);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_vertex(vec_type v);
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.in_x  <= v[0];
      req_chan.in_y  <= v[1];
      req_chan.in_z  <= v[2];
      req_chan.in_w  <= v[3];
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // bursts of back-to-back transfers separated by idle gaps
   task automatic paced_send(vec_type v);
      send_vertex(v);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         repeat (($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3))
         begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(0, 20);
      end
   endtask

   task automatic send_random(int count);
      repeat (count) paced_send(random_vertex());
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (xform_sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   initial begin : stimulus
      int kind;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      req_chan.valid = 1'b0;
      req_chan.in_x  = '0;
      req_chan.in_y  = '0;
      req_chan.in_z  = '0;
      req_chan.in_w  = '0;
      burst_left     = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity after reset
      paced_send(make_vertex('0, '0, '0, '0));
      paced_send(make_vertex(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_ONE));
      paced_send(make_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      paced_send(make_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      paced_send(make_vertex(-32'sd1, -32'sd1, -32'sd1, -32'sd1));
      paced_send(make_vertex(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555));
      send_random(150);
      drain_pipeline();

      // halves and a translation, so odd values land between steps and floor
      next_matrix[ROW0_COLS01] = {32'h0, Q_HALF};
      next_matrix[ROW0_COLS23] = '0;
      next_matrix[ROW1_COLS01] = {-Q_HALF, 32'h0};
      next_matrix[ROW1_COLS23] = '0;
      next_matrix[ROW2_COLS01] = '0;
      next_matrix[ROW2_COLS23] = {32'h0, Q_HALF};
      next_matrix[ROW3_COLS01] = {32'sh0000_C000, 32'shFFFF_C000};
      next_matrix[ROW3_COLS23] = {Q_ONE, 32'h0};
      load_matrix();
      paced_send(make_vertex(-32'sd1, 32'sd1, -32'sd3, '0));
      paced_send(make_vertex(32'sd1, -32'sd1, 32'sd3, '0));
      paced_send(make_vertex(-32'sd3, 32'sd3, -32'sd1, Q_ONE));
      paced_send(make_vertex(Q_MIN, Q_MIN, Q_MAX, -Q_ONE));
      send_random(150);
      drain_pipeline();

      // largest positive entries everywhere
      for (int k = 0; k < NUM_CSR; k++) next_matrix[k] = {Q_MAX, Q_MAX};
      load_matrix();
      paced_send(make_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      paced_send(make_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      paced_send(make_vertex(Q_MAX, Q_MIN, Q_MAX, Q_MIN));
      paced_send(make_vertex(32'sd1, '0, '0, '0));
      send_random(60);
      drain_pipeline();

      // most negative entries everywhere: all-min vertex gives the largest sum
      for (int k = 0; k < NUM_CSR; k++) next_matrix[k] = {Q_MIN, Q_MIN};
      load_matrix();
      paced_send(make_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      paced_send(make_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      paced_send(make_vertex('0, '0, '0, '0));
      paced_send(make_vertex(-32'sd1, '0, '0, '0));
      send_random(60);
      drain_pipeline();

      for (int p = 0; p < 6; p++) begin
         kind = p % 3;
         for (int k = 0; k < NUM_CSR; k++)
            next_matrix[k] = {random_element(kind), random_element(kind)};
         load_matrix();
         send_random(95);
         // sender holds off until every outstanding result is back
         drain_pipeline();
         send_random(95);
         drain_pipeline();
      end

      repeat (6) @(posedge clock);
      if (xform_sb.errors == 0 && xform_sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== vertex_matrix_transform.f =====
+incdir+rtl/core
rtl/core/vmt_pkg.sv
rtl/core/vmt_req_if.sv
rtl/core/vmt_rsp_if.sv
rtl/core/vmt_column.sv
rtl/core/vertex_matrix_transform.sv
sim/vmt_tb_pkg.sv
sim/tb_vertex_matrix_transform.sv
